@@ src/cfpid_pkg.sv @@
// Shared types and constants for the complementary filter PID motor drive.
package cfpid_pkg;

  // Configuration register map
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_BLEND_WEIGHT = 3'd3,
    CFG_TICK_PERIOD  = 3'd4,
    CFG_DRIVE_LIMIT  = 3'd5,
    CFG_FULL_SCALE   = 3'd6,
    CFG_PWM_PERIOD   = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [31:0] RST_GAIN_P       = 32'd1966080;
  localparam logic [31:0] RST_GAIN_I       = 32'd0;
  localparam logic [31:0] RST_GAIN_D       = 32'd131072;
  localparam logic [16:0] RST_BLEND_WEIGHT = 17'd64225;
  localparam logic [15:0] RST_TICK_PERIOD  = 16'd655;
  localparam logic [30:0] RST_DRIVE_LIMIT  = 31'd32768000;
  localparam logic [30:0] RST_FULL_SCALE   = 31'd65536000;
  localparam logic [15:0] RST_PWM_PERIOD   = 16'd1000;

  // Fixed-point limits
  localparam logic [16:0] BLEND_ONE  = 17'h10000;
  localparam logic [30:0] FS_MIN     = 31'h10000;
  localparam logic [31:0] I32_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN    = 32'h8000_0000;
  localparam logic [47:0] I48_MAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] I48_MIN    = 48'h8000_0000_0000;
  localparam logic [61:0] TERM_CAP   = 62'h2000_0000_0000_0000;
  localparam logic [15:0] DUTY_MAX   = 16'hFFFF;

  // Shared multiplier and divider widths
  localparam int unsigned MulW    = 33;
  localparam int unsigned DivNumW = 49;
  localparam int unsigned DivDenW = 31;
  localparam int unsigned DivCntW = 6;

  localparam logic [DivCntW-1:0] DER_DIV_STEPS  = 6'd49;
  localparam logic [DivCntW-1:0] DUTY_DIV_STEPS = 6'd32;

  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
  } div_sts_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GDT,
    ST_BLA,
    ST_BLB,
    ST_PIT,
    ST_ERR,
    ST_EDT,
    ST_ESUM,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_CLIP,
    ST_DMUL,
    ST_DDIV,
    ST_DWAIT
  } ctl_state_t;

  // PID term under evaluation
  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_sel_t;

endpackage

@@ src/cfpid_mul.sv @@
// Shared signed multiplier with a registered product.
module cfpid_mul (
  input  logic                                clk,
  input  logic signed [cfpid_pkg::MulW-1:0]   op_a,
  input  logic signed [cfpid_pkg::MulW-1:0]   op_b,
  output logic signed [2*cfpid_pkg::MulW-1:0] prod_r
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

@@ src/cfpid_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module cfpid_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfpid_pkg::div_cmd_t               cmd,
  input  logic [cfpid_pkg::DivNumW-1:0]     num,
  input  logic [cfpid_pkg::DivDenW-1:0]     rem_init,
  input  logic [cfpid_pkg::DivDenW-1:0]     divisor,
  output cfpid_pkg::div_sts_t               sts,
  output logic [cfpid_pkg::DivNumW-1:0]     quot
);

  logic                            busy_r;
  logic [cfpid_pkg::DivCntW-1:0]   cnt_r;
  logic [cfpid_pkg::DivDenW-1:0]   rem_r;
  logic [cfpid_pkg::DivDenW-1:0]   den_r;
  logic [cfpid_pkg::DivNumW-1:0]   num_r;
  logic [cfpid_pkg::DivDenW:0]     trial;
  logic [cfpid_pkg::DivDenW:0]     diff;
  logic                            qbit;
  logic [cfpid_pkg::DivDenW-1:0]   rem_nxt;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, num_r[cfpid_pkg::DivNumW-1]};
    diff    = trial - {1'b0, den_r};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? diff[cfpid_pkg::DivDenW-1:0] : trial[cfpid_pkg::DivDenW-1:0];
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= cmd.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == cfpid_pkg::DivCntW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= rem_init;
      den_r <= divisor;
      num_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[cfpid_pkg::DivNumW-2:0], qbit};
    end
  end

  assign sts.busy = busy_r;
  assign quot     = num_r;

endmodule

@@ src/complementary_filter_pid_motor_drive.sv @@
// Top level: complementary filter pitch estimate, PID and PWM drive sequencer.
//
//  channel | handshake           | beat contents
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_stall | in_gyro_rate, in_accel_angle
//  out     | out_valid/out_stall | out_pwm_compare, out_forward, out_pitch_estimate
//  cfg     | cfg_we              | cfg_idx, cfg_data (write only)
//
// An accepted beat runs 7 filter steps, the 49-step derivative division (P and I
// terms overlap it), 7 D term, clip and duty multiply steps and the 32-step duty
// division; it is then loaded into the output register, waiting while out_stall
// holds an earlier result, and the next beat can be taken in the cycle after the
// load. in_stall is high until that load; the next beat is taken while the
// result waits on out_stall. Reset (synchronous, active low) clears control state.
module complementary_filter_pid_motor_drive (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [31:0]                   in_gyro_rate,
  input  logic signed [31:0]                   in_accel_angle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [15:0]                          out_pwm_compare,
  output logic                                 out_forward,
  output logic signed [31:0]                   out_pitch_estimate,
  input  logic                                 cfg_we,
  input  logic [cfpid_pkg::CfgIdxW-1:0]        cfg_idx,
  input  logic [cfpid_pkg::CfgDataW-1:0]       cfg_data
);

  // Configuration registers
  logic [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [16:0] blend_r;
  logic [15:0] tick_r;
  logic [30:0] limit_r;
  logic [30:0] fscale_r;
  logic [15:0] pperiod_r;

  // Effective configuration values
  logic [16:0] a_eff, a_cmp;
  logic [15:0] dt_eff;
  logic [30:0] fs_eff;

  // Sequencer
  cfpid_pkg::ctl_state_t state_r, state_nxt;
  cfpid_pkg::term_sel_t  tsel_r;

  // Datapath registers
  logic signed [31:0] gyro_r, accel_r;
  logic signed [31:0] pitch_r;
  logic signed [47:0] esum_r;
  logic signed [31:0] lerr_r;
  logic signed [31:0] err_r;
  logic signed [32:0] sum1_r;
  logic signed [50:0] acc_r;
  logic signed [32:0] diff_r;
  logic [30:0]        magp_r;
  logic [47:0]        magi_r;
  logic               dneg_r;
  logic               tneg_r;
  logic [44:0]        hi_r;
  logic               hbig_r;
  logic [61:0]        term_r;
  logic signed [63:0] u_r;
  logic [30:0]        magu_r;
  logic               fwd_r;

  // Output register
  logic               out_valid_r;
  logic [15:0]        out_pwm_r;
  logic               out_fwd_r;
  logic signed [31:0] out_pitch_r;

  // Shared units
  logic signed [cfpid_pkg::MulW-1:0]   mul_a, mul_b;
  logic signed [2*cfpid_pkg::MulW-1:0] prod;
  cfpid_pkg::div_cmd_t                 div_cmd;
  cfpid_pkg::div_sts_t                 div_sts;
  logic [cfpid_pkg::DivNumW-1:0]       div_num;
  logic [cfpid_pkg::DivDenW-1:0]       div_rem;
  logic [cfpid_pkg::DivDenW-1:0]       div_den;
  logic [cfpid_pkg::DivNumW-1:0]       div_quot;

  // Combinational datapath
  logic signed [31:0] prod_sh;
  logic signed [32:0] sum1;
  logic signed [50:0] blend_sum;
  logic [34:0]        pit_sh;
  logic [31:0]        pitch_sat;
  logic [31:0]        err_neg;
  logic signed [48:0] esum_sum;
  logic [47:0]        esum_sat;
  logic [32:0]        dmag;
  logic [31:0]        gsel;
  logic [48:0]        msel;
  logic               ssel;
  logic [61:0]        term_sum;
  logic [63:0]        term64;
  logic signed [63:0] lim_s, neg_lim;
  logic [63:0]        u_abs;
  logic [30:0]        magu;
  logic               fwd;
  logic               out_load;

  cfpid_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  cfpid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .num      (div_num),
    .rem_init (div_rem),
    .divisor  (div_den),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  // Clamp configuration to its usable range
  always_comb begin
    a_eff  = blend_r[16] ? cfpid_pkg::BLEND_ONE : blend_r;
    a_cmp  = cfpid_pkg::BLEND_ONE - a_eff;
    dt_eff = (tick_r == 16'd0) ? 16'd1 : tick_r;
    fs_eff = (fscale_r[30:16] == 15'd0) ? cfpid_pkg::FS_MIN : fscale_r;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r  <= cfpid_pkg::RST_GAIN_P;
      gain_i_r  <= cfpid_pkg::RST_GAIN_I;
      gain_d_r  <= cfpid_pkg::RST_GAIN_D;
      blend_r   <= cfpid_pkg::RST_BLEND_WEIGHT;
      tick_r    <= cfpid_pkg::RST_TICK_PERIOD;
      limit_r   <= cfpid_pkg::RST_DRIVE_LIMIT;
      fscale_r  <= cfpid_pkg::RST_FULL_SCALE;
      pperiod_r <= cfpid_pkg::RST_PWM_PERIOD;
    end else if (cfg_we) begin
      unique case (cfpid_pkg::cfg_reg_t'(cfg_idx))
        cfpid_pkg::CFG_GAIN_P:       gain_p_r  <= cfg_data;
        cfpid_pkg::CFG_GAIN_I:       gain_i_r  <= cfg_data;
        cfpid_pkg::CFG_GAIN_D:       gain_d_r  <= cfg_data;
        cfpid_pkg::CFG_BLEND_WEIGHT: blend_r   <= cfg_data[16:0];
        cfpid_pkg::CFG_TICK_PERIOD:  tick_r    <= cfg_data[15:0];
        cfpid_pkg::CFG_DRIVE_LIMIT:  limit_r   <= cfg_data[30:0];
        cfpid_pkg::CFG_FULL_SCALE:   fscale_r  <= cfg_data[30:0];
        cfpid_pkg::CFG_PWM_PERIOD:   pperiod_r <= cfg_data[15:0];
      endcase
    end
  end

  // Filter and PID arithmetic around the registered product
  always_comb begin
    prod_sh   = $signed(prod[47:16]);
    sum1      = {pitch_r[31], pitch_r} + {prod_sh[31], prod_sh};
    blend_sum = acc_r + $signed(prod[50:0]);
    pit_sh    = blend_sum[50:16];
    if ((&pit_sh[34:31]) || !(|pit_sh[34:31])) begin
      pitch_sat = pit_sh[31:0];
    end else begin
      pitch_sat = pit_sh[34] ? cfpid_pkg::I32_MIN : cfpid_pkg::I32_MAX;
    end
    err_neg  = (pitch_r == $signed(cfpid_pkg::I32_MIN)) ? cfpid_pkg::I32_MAX
                                                        : 32'(-pitch_r);
    esum_sum = {esum_r[47], esum_r} + {{17{prod_sh[31]}}, prod_sh};
    if (esum_sum[48] != esum_sum[47]) begin
      esum_sat = esum_sum[48] ? cfpid_pkg::I48_MIN : cfpid_pkg::I48_MAX;
    end else begin
      esum_sat = esum_sum[47:0];
    end
    dmag = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);
  end

  // Gain, magnitude and sign of the current term
  always_comb begin
    case (tsel_r)
      cfpid_pkg::TERM_P: begin
        gsel = gain_p_r;
        msel = {18'd0, magp_r};
        ssel = err_r[31];
      end
      cfpid_pkg::TERM_I: begin
        gsel = gain_i_r;
        msel = {1'b0, magi_r};
        ssel = esum_r[47];
      end
      cfpid_pkg::TERM_D: begin
        gsel = gain_d_r;
        msel = div_quot;
        ssel = dneg_r;
      end
      default: begin
        gsel = '0;
        msel = '0;
        ssel = 1'b0;
      end
    endcase
    term_sum = {1'b0, hi_r, 16'd0} + {14'd0, prod[63:16]};
    term64   = {2'd0, term_r};
  end

  // Clip and split into magnitude and direction
  always_comb begin
    lim_s   = $signed({33'd0, limit_r});
    neg_lim = -lim_s;
    u_abs   = u_r[63] ? 64'(-u_r) : 64'(u_r);
    if (u_r > lim_s) begin
      magu = limit_r;
      fwd  = (limit_r != 31'd0);
    end else if (u_r < neg_lim) begin
      magu = limit_r;
      fwd  = 1'b0;
    end else begin
      magu = u_abs[30:0];
      fwd  = !u_r[63] && (u_r != 64'sd0);
    end
  end

  assign out_load = (state_r == cfpid_pkg::ST_DWAIT) && !div_sts.busy &&
                    (!out_valid_r || !out_stall);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfpid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, multiplier operands and divider commands
  always_comb begin
    state_nxt     = state_r;
    mul_a         = '0;
    mul_b         = '0;
    div_cmd.start = 1'b0;
    div_cmd.steps = cfpid_pkg::DER_DIV_STEPS;
    div_num       = {dmag, 16'd0};
    div_rem       = '0;
    div_den       = {15'd0, dt_eff};
    unique case (state_r)
      cfpid_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = cfpid_pkg::ST_GDT;
      end
      cfpid_pkg::ST_GDT: begin
        mul_a     = {gyro_r[31], gyro_r};
        mul_b     = {17'd0, dt_eff};
        state_nxt = cfpid_pkg::ST_BLA;
      end
      cfpid_pkg::ST_BLA: begin
        mul_a     = {accel_r[31], accel_r};
        mul_b     = {16'd0, a_cmp};
        state_nxt = cfpid_pkg::ST_BLB;
      end
      cfpid_pkg::ST_BLB: begin
        mul_a     = sum1_r;
        mul_b     = {16'd0, a_eff};
        state_nxt = cfpid_pkg::ST_PIT;
      end
      cfpid_pkg::ST_PIT: begin
        state_nxt = cfpid_pkg::ST_ERR;
      end
      cfpid_pkg::ST_ERR: begin
        state_nxt = cfpid_pkg::ST_EDT;
      end
      cfpid_pkg::ST_EDT: begin
        mul_a     = {err_r[31], err_r};
        mul_b     = {17'd0, dt_eff};
        state_nxt = cfpid_pkg::ST_ESUM;
      end
      cfpid_pkg::ST_ESUM: begin
        div_cmd.start = 1'b1;
        state_nxt     = cfpid_pkg::ST_T0;
      end
      cfpid_pkg::ST_T0: begin
        mul_a = {1'b0, gsel};
        mul_b = {16'd0, msel[48:32]};
        if (!(tsel_r == cfpid_pkg::TERM_D && div_sts.busy)) begin
          state_nxt = cfpid_pkg::ST_T1;
        end
      end
      cfpid_pkg::ST_T1: begin
        mul_a     = {1'b0, gsel};
        mul_b     = {1'b0, msel[31:0]};
        state_nxt = cfpid_pkg::ST_T2;
      end
      cfpid_pkg::ST_T2: begin
        state_nxt = cfpid_pkg::ST_T3;
      end
      cfpid_pkg::ST_T3: begin
        state_nxt = (tsel_r == cfpid_pkg::TERM_D) ? cfpid_pkg::ST_CLIP
                                                  : cfpid_pkg::ST_T0;
      end
      cfpid_pkg::ST_CLIP: begin
        state_nxt = cfpid_pkg::ST_DMUL;
      end
      cfpid_pkg::ST_DMUL: begin
        mul_a     = {2'd0, magu_r};
        mul_b     = {17'd0, pperiod_r};
        state_nxt = cfpid_pkg::ST_DDIV;
      end
      cfpid_pkg::ST_DDIV: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = cfpid_pkg::DUTY_DIV_STEPS;
        div_num       = {prod[31:0], 17'd0};
        div_rem       = {16'd0, prod[46:32]};
        div_den       = fs_eff;
        state_nxt     = cfpid_pkg::ST_DWAIT;
      end
      cfpid_pkg::ST_DWAIT: begin
        if (out_load) state_nxt = cfpid_pkg::ST_IDLE;
      end
    endcase
  end

  // Architectural filter and PID state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= '0;
      esum_r  <= '0;
      lerr_r  <= '0;
      tsel_r  <= cfpid_pkg::TERM_P;
    end else begin
      if (state_r == cfpid_pkg::ST_PIT) pitch_r <= $signed(pitch_sat);
      if (state_r == cfpid_pkg::ST_EDT) lerr_r  <= err_r;
      if (state_r == cfpid_pkg::ST_ESUM) begin
        esum_r <= $signed(esum_sat);
        tsel_r <= cfpid_pkg::TERM_P;
      end
      // Advance to the next PID term
      if (state_r == cfpid_pkg::ST_T3) begin
        case (tsel_r)
          cfpid_pkg::TERM_P: tsel_r <= cfpid_pkg::TERM_I;
          cfpid_pkg::TERM_I: tsel_r <= cfpid_pkg::TERM_D;
          default:           tsel_r <= cfpid_pkg::TERM_P;
        endcase
      end
    end
  end

  // Working registers of one item
  always_ff @(posedge clk) begin
    case (state_r)
      cfpid_pkg::ST_IDLE: begin
        gyro_r  <= in_gyro_rate;
        accel_r <= in_accel_angle;
      end
      cfpid_pkg::ST_BLA:  sum1_r <= sum1;
      cfpid_pkg::ST_BLB:  acc_r  <= $signed(prod[50:0]);
      cfpid_pkg::ST_ERR:  err_r  <= $signed(err_neg);
      cfpid_pkg::ST_EDT: begin
        diff_r <= {err_r[31], err_r} - {lerr_r[31], lerr_r};
        magp_r <= err_r[31] ? 31'(-err_r) : err_r[30:0];
      end
      cfpid_pkg::ST_ESUM: begin
        dneg_r <= diff_r[32];
        u_r    <= '0;
      end
      cfpid_pkg::ST_T0: begin
        tneg_r <= ssel;
        if (tsel_r == cfpid_pkg::TERM_P) begin
          magi_r <= esum_r[47] ? 48'(-esum_r) : 48'(esum_r);
        end
      end
      cfpid_pkg::ST_T1: begin
        hi_r   <= prod[44:0];
        hbig_r <= |prod[48:45];
      end
      cfpid_pkg::ST_T2: begin
        term_r <= (hbig_r || term_sum > cfpid_pkg::TERM_CAP) ? cfpid_pkg::TERM_CAP
                                                             : term_sum;
      end
      cfpid_pkg::ST_T3: begin
        u_r <= tneg_r ? (u_r - $signed(term64)) : (u_r + $signed(term64));
      end
      cfpid_pkg::ST_CLIP: begin
        magu_r <= magu;
        fwd_r  <= fwd;
      end
      default: begin
      end
    endcase
  end

  // Output register: load the finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pwm_r   <= (div_quot[31:16] != 16'd0) ? cfpid_pkg::DUTY_MAX : div_quot[15:0];
      out_fwd_r   <= fwd_r;
      out_pitch_r <= pitch_r;
    end
  end

  assign in_stall           = (state_r != cfpid_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_pwm_compare    = out_pwm_r;
  assign out_forward        = out_fwd_r;
  assign out_pitch_estimate = out_pitch_r;

`ifndef SYNTH
  // A result beat appears only at the end of the duty division
  a_out_from_dwait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == cfpid_pkg::ST_DWAIT)
    else $error("result loaded outside the final wait state");

  // The shared divider is never restarted mid-run
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // Clipped drive magnitude never exceeds the limit
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cfpid_pkg::ST_CLIP |=> magu_r <= limit_r)
    else $error("clipped magnitude above drive limit");

  // Negated error stays inside the symmetric 32-bit range
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cfpid_pkg::ST_ERR |=> err_r != $signed(cfpid_pkg::I32_MIN))
    else $error("error saturation missed");

  // An accepted beat starts the sequence
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == cfpid_pkg::ST_GDT)
    else $error("accepted beat did not start the sequence");
`endif

endmodule
